// File: sv/pas_pkg.sv
package pas_pkg;

   // Field widths of the event and snapshot beats.
   localparam int OP_WIDTH          = 2;
   localparam int BYTE_COUNT_WIDTH  = 13;
   localparam int TIME_WIDTH        = 32;
   localparam int COUNTER_WIDTH     = 32;
   localparam int BYTE_SUM_WIDTH    = 48;
   localparam int INTERVAL_WIDTH    = 23;
   localparam int RATE_WIDTH        = 28;
   localparam int CSR_INDEX_WIDTH   = 2;

   // Rate arithmetic and packet size limit.
   localparam int RATE_FRACTION_BITS = 8;
   localparam int MAX_PACKET_BYTES   = 4096;
   localparam int US_PER_MS          = 1000;
   localparam int US_PER_SECOND      = 1000000;
   localparam int ALPHA_BITS         = 16;
   localparam int ALPHA_Q16          = 13107;

   // Serial divider sizing: both quotients come out of the same step count.
   localparam int RATE_NUM_WIDTH  = 20 + RATE_FRACTION_BITS;
   localparam int DIV_STEPS       = (RATE_NUM_WIDTH > TIME_WIDTH) ? RATE_NUM_WIDTH : TIME_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_STEPS);
   localparam int MS_REM_WIDTH    = $clog2(US_PER_MS);
   localparam logic [DIV_STEPS-1:0] RATE_NUMERATOR =
      DIV_STEPS'(64'(US_PER_SECOND) << RATE_FRACTION_BITS);

   // Threshold reset values in milliseconds.
   localparam logic [INTERVAL_WIDTH-1:0] GAP_LOW_RESET  = INTERVAL_WIDTH'(300);
   localparam logic [INTERVAL_WIDTH-1:0] GAP_MID_RESET  = INTERVAL_WIDTH'(500);
   localparam logic [INTERVAL_WIDTH-1:0] GAP_HIGH_RESET = INTERVAL_WIDTH'(1000);

   // Event operation codes.
   localparam logic [OP_WIDTH-1:0] OP_PACKET  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_TIMEOUT = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_ERROR   = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR   = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP_LOW  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP_MID  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP_HIGH = 2'd2;

   // Status handed from the divider to the statistics logic.
   typedef struct packed {
      logic                      done;
      logic [INTERVAL_WIDTH-1:0] interval_ms;
      logic [RATE_WIDTH-1:0]     rate;
   } div_result_type;

endpackage

// File: sv/pas_channels.sv
// Event channel: one packet, timeout, error or clear per beat.
interface pas_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [pas_pkg::OP_WIDTH-1:0]          operation;
   logic [pas_pkg::BYTE_COUNT_WIDTH-1:0]  byte_count;
   logic [pas_pkg::TIME_WIDTH-1:0]        arrival_time_us;

   modport source (output valid, operation, byte_count, arrival_time_us, input ready);
   modport sink (input valid, operation, byte_count, arrival_time_us, output ready);
endinterface

// Snapshot channel: one statistics snapshot per beat.
interface pas_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [pas_pkg::COUNTER_WIDTH-1:0]      packet_tally;
   logic [pas_pkg::BYTE_SUM_WIDTH-1:0]     byte_tally;
   logic [pas_pkg::COUNTER_WIDTH-1:0]      timeouts_total;
   logic [pas_pkg::COUNTER_WIDTH-1:0]      errors_total;
   logic [pas_pkg::INTERVAL_WIDTH-1:0]     last_interval_ms;
   logic [pas_pkg::INTERVAL_WIDTH-1:0]     max_interval_ms;
   logic [pas_pkg::COUNTER_WIDTH-1:0]      gaps_low;
   logic [pas_pkg::COUNTER_WIDTH-1:0]      gaps_mid;
   logic [pas_pkg::COUNTER_WIDTH-1:0]      gaps_high;
   logic [pas_pkg::INTERVAL_WIDTH-1:0]     recent_gap_ms;
   logic [pas_pkg::COUNTER_WIDTH-1:0]      last_gap_packet;
   logic [pas_pkg::RATE_WIDTH-1:0]         rate_average;

   modport source (output valid, packet_tally, byte_tally, timeouts_total, errors_total,
                   last_interval_ms, max_interval_ms, gaps_low, gaps_mid, gaps_high,
                   recent_gap_ms, last_gap_packet, rate_average, input ready);
   modport sink (input valid, packet_tally, byte_tally, timeouts_total, errors_total,
                 last_interval_ms, max_interval_ms, gaps_low, gaps_mid, gaps_high,
                 recent_gap_ms, last_gap_packet, rate_average, output ready);
endinterface

// Register write channel.
interface pas_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [pas_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [pas_pkg::INTERVAL_WIDTH-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pas_divider.sv
// Two restoring dividers stepped side by side, one quotient bit per cycle:
// the interval dt / 1000 and the rate numerator / dt.
module pas_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [pas_pkg::TIME_WIDTH-1:0]      dt,
   output pas_pkg::div_result_type             result
);

   localparam int STEPS  = pas_pkg::DIV_STEPS;
   localparam int CW     = pas_pkg::DIV_COUNT_WIDTH;
   localparam int MRW    = pas_pkg::MS_REM_WIDTH;
   localparam int TW     = pas_pkg::TIME_WIDTH;
   localparam int RW     = pas_pkg::RATE_WIDTH;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [TW-1:0]   divisor_ff, divisor_in;

   // Dividend shifts out at the top while quotient bits shift in at the bottom.
   logic [STEPS-1:0] ms_quot_ff, ms_quot_in;
   logic [MRW-1:0]   ms_rem_ff, ms_rem_in;
   logic [STEPS-1:0] rate_quot_ff, rate_quot_in;
   logic [TW-1:0]    rate_rem_ff, rate_rem_in;

   logic [MRW:0]     ms_shift;
   logic             ms_take;
   logic [TW:0]      rate_shift;
   logic             rate_take;

   // One trial subtraction per divider.
   always_comb begin
      ms_shift   = {ms_rem_ff, ms_quot_ff[STEPS-1]};
      ms_take    = ms_shift >= (MRW+1)'(pas_pkg::US_PER_MS);
      rate_shift = {rate_rem_ff, rate_quot_ff[STEPS-1]};
      rate_take  = rate_shift >= {1'b0, divisor_ff};
   end

   // Load on start, then step until the count runs out.
   always_comb begin
      busy_in      = busy_ff;
      done_in      = 1'b0;
      count_in     = count_ff;
      divisor_in   = divisor_ff;
      ms_quot_in   = ms_quot_ff;
      ms_rem_in    = ms_rem_ff;
      rate_quot_in = rate_quot_ff;
      rate_rem_in  = rate_rem_ff;
      if (start) begin
         busy_in      = 1'b1;
         count_in     = '0;
         divisor_in   = dt;
         ms_quot_in   = STEPS'(dt);
         ms_rem_in    = '0;
         rate_quot_in = pas_pkg::RATE_NUMERATOR;
         rate_rem_in  = '0;
      end else if (busy_ff) begin
         ms_quot_in   = {ms_quot_ff[STEPS-2:0], ms_take};
         ms_rem_in    = ms_take ? MRW'(ms_shift - (MRW+1)'(pas_pkg::US_PER_MS))
                                : ms_shift[MRW-1:0];
         rate_quot_in = {rate_quot_ff[STEPS-2:0], rate_take};
         rate_rem_in  = rate_take ? TW'(rate_shift - {1'b0, divisor_ff})
                                  : rate_shift[TW-1:0];
         count_in     = count_ff + 1'b1;
         if (count_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      divisor_ff   <= divisor_in;
      ms_quot_ff   <= ms_quot_in;
      ms_rem_ff    <= ms_rem_in;
      rate_quot_ff <= rate_quot_in;
      rate_rem_ff  <= rate_rem_in;
   end

   // The rate quotient saturates to the field width.
   always_comb begin
      result.done        = done_ff;
      result.interval_ms = ms_quot_ff[pas_pkg::INTERVAL_WIDTH-1:0];
      result.rate        = (|rate_quot_ff[STEPS-1:RW]) ? '1 : rate_quot_ff[RW-1:0];
   end

endmodule

// File: sv/packet_arrival_statistics.sv
// A packet that follows an earlier one passes from its event beat to its snapshot
// beat through 32 serial divider steps, a state that takes the quotients, the
// scale and blend states when the average is blended, and the output register.
// Any other event goes from idle to the emit state and then the output register.
// The block takes one event at a time; a new event beat is taken only in idle.
// Reset (synchronous): all statistics zero, thresholds 300, 500 and 1000 ms.
module packet_arrival_statistics (
   input  logic       clock,
   input  logic       reset,
   pas_req_if.sink    req_bus,
   pas_rsp_if.source  rsp_bus,
   pas_csr_if.sink    csr_bus
);

   localparam int CTW = pas_pkg::COUNTER_WIDTH;
   localparam int BTW = pas_pkg::BYTE_SUM_WIDTH;
   localparam int IW  = pas_pkg::INTERVAL_WIDTH;
   localparam int RW  = pas_pkg::RATE_WIDTH;
   localparam int TW  = pas_pkg::TIME_WIDTH;
   localparam int BCW = pas_pkg::BYTE_COUNT_WIDTH;
   localparam int PW  = pas_pkg::ALPHA_BITS + RW;

   localparam logic [pas_pkg::ALPHA_BITS-1:0] ALPHA_NEW = pas_pkg::ALPHA_BITS'(pas_pkg::ALPHA_Q16);
   localparam logic [pas_pkg::ALPHA_BITS-1:0] ALPHA_OLD =
      pas_pkg::ALPHA_BITS'((1 << pas_pkg::ALPHA_BITS) - pas_pkg::ALPHA_Q16);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DIVIDE    = 3'd1;
   localparam logic [2:0] ST_SCALE_NEW = 3'd2;
   localparam logic [2:0] ST_SCALE_OLD = 3'd3;
   localparam logic [2:0] ST_BLEND     = 3'd4;
   localparam logic [2:0] ST_EMIT      = 3'd5;

   typedef struct packed {
      logic [CTW-1:0] packets;
      logic [BTW-1:0] bytes;
      logic [CTW-1:0] timeouts;
      logic [CTW-1:0] errors;
      logic [IW-1:0]  recent;
      logic [IW-1:0]  largest;
      logic [CTW-1:0] gap_low;
      logic [CTW-1:0] gap_mid;
      logic [CTW-1:0] gap_high;
      logic [IW-1:0]  gap_ms;
      logic [CTW-1:0] gap_packet;
      logic [RW-1:0]  average;
      logic [TW-1:0]  prev_time;
      logic           seen;
   } stats_type;

   function automatic logic [CTW-1:0] sat_inc(input logic [CTW-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   logic [2:0]     state_ff, state_in;
   stats_type      stats_ff, stats_in;
   stats_type      snap_ff;
   logic           rsp_valid_ff;
   logic           dt_zero_ff, dt_zero_in;
   logic [RW-1:0]  inst_ff, inst_in;
   logic [PW-1:0]  prod_new_ff, prod_new_in;
   logic [PW-1:0]  prod_old_ff, prod_old_in;
   logic [IW-1:0]  thr_low_ff, thr_mid_ff, thr_high_ff;

   logic           req_fire;
   logic           rsp_free;
   logic           div_start;
   logic [TW-1:0]  dt_now;
   logic [BCW-1:0] bytes_clamped;
   logic [BTW:0]   byte_sum;
   logic [PW:0]    blend_sum;
   logic [PW-pas_pkg::ALPHA_BITS:0] blend_shifted;
   logic [IW-1:0]  ms;
   pas_pkg::div_result_type div_result;

   pas_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .dt     (dt_now),
      .result (div_result)
   );

   // Handshakes.
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Per-event arithmetic.
   always_comb begin
      dt_now        = req_bus.arrival_time_us - stats_ff.prev_time;
      bytes_clamped = (req_bus.byte_count > BCW'(pas_pkg::MAX_PACKET_BYTES))
                      ? BCW'(pas_pkg::MAX_PACKET_BYTES) : req_bus.byte_count;
      byte_sum      = {1'b0, stats_ff.bytes} + (BTW+1)'(bytes_clamped);
      blend_sum     = {1'b0, prod_new_ff} + {1'b0, prod_old_ff};
      blend_shifted = blend_sum[PW:pas_pkg::ALPHA_BITS];
      ms            = div_result.interval_ms;
   end

   // Statistics update sequencer.
   always_comb begin
      state_in    = state_ff;
      stats_in    = stats_ff;
      dt_zero_in  = dt_zero_ff;
      inst_in     = inst_ff;
      prod_new_in = prod_new_ff;
      prod_old_in = prod_old_ff;
      div_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EMIT;
               case (req_bus.operation)
                  pas_pkg::OP_PACKET: begin
                     // A zero-length packet changes nothing.
                     if (req_bus.byte_count != '0) begin
                        stats_in.packets   = sat_inc(stats_ff.packets);
                        stats_in.bytes     = byte_sum[BTW] ? '1 : byte_sum[BTW-1:0];
                        stats_in.prev_time = req_bus.arrival_time_us;
                        stats_in.seen      = 1'b1;
                        if (stats_ff.seen) begin
                           div_start  = 1'b1;
                           dt_zero_in = (dt_now == '0);
                           state_in   = ST_DIVIDE;
                        end
                     end
                  end
                  pas_pkg::OP_TIMEOUT: stats_in.timeouts = sat_inc(stats_ff.timeouts);
                  pas_pkg::OP_ERROR:   stats_in.errors = sat_inc(stats_ff.errors);
                  pas_pkg::OP_CLEAR:   stats_in = '0;
                  default:             stats_in = '0;
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_result.done) begin
               stats_in.recent = ms;
               if (ms > stats_ff.largest) begin
                  stats_in.largest = ms;
               end
               if (ms >= thr_low_ff) begin
                  stats_in.gap_low    = sat_inc(stats_ff.gap_low);
                  stats_in.gap_ms     = ms;
                  stats_in.gap_packet = stats_ff.packets;
               end
               if (ms >= thr_mid_ff) begin
                  stats_in.gap_mid = sat_inc(stats_ff.gap_mid);
               end
               if (ms >= thr_high_ff) begin
                  stats_in.gap_high = sat_inc(stats_ff.gap_high);
               end
               inst_in = div_result.rate;
               // A zero difference leaves the average alone; an empty average is seeded.
               if (dt_zero_ff) begin
                  state_in = ST_EMIT;
               end else if (stats_ff.average == '0) begin
                  stats_in.average = div_result.rate;
                  state_in         = ST_EMIT;
               end else begin
                  state_in = ST_SCALE_NEW;
               end
            end
         end
         ST_SCALE_NEW: begin
            prod_new_in = ALPHA_NEW * inst_ff;
            state_in    = ST_SCALE_OLD;
         end
         ST_SCALE_OLD: begin
            prod_old_in = ALPHA_OLD * stats_ff.average;
            state_in    = ST_BLEND;
         end
         ST_BLEND: begin
            stats_in.average = blend_shifted[RW] ? '1 : blend_shifted[RW-1:0];
            state_in         = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stats_ff <= '0;
      end else begin
         state_ff <= state_in;
         stats_ff <= stats_in;
      end
      dt_zero_ff  <= dt_zero_in;
      inst_ff     <= inst_in;
      prod_new_ff <= prod_new_in;
      prod_old_ff <= prod_old_in;
   end

   // Threshold registers; writes to an unused index fall through.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_low_ff  <= pas_pkg::GAP_LOW_RESET;
         thr_mid_ff  <= pas_pkg::GAP_MID_RESET;
         thr_high_ff <= pas_pkg::GAP_HIGH_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            pas_pkg::CSR_GAP_LOW:  thr_low_ff <= csr_bus.data;
            pas_pkg::CSR_GAP_MID:  thr_mid_ff <= csr_bus.data;
            pas_pkg::CSR_GAP_HIGH: thr_high_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Snapshot output register; it frees the sequencer while a beat waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_EMIT && rsp_free) begin
         snap_ff <= stats_ff;
      end
   end

   always_comb begin
      rsp_bus.valid            = rsp_valid_ff;
      rsp_bus.packet_tally     = snap_ff.packets;
      rsp_bus.byte_tally       = snap_ff.bytes;
      rsp_bus.timeouts_total   = snap_ff.timeouts;
      rsp_bus.errors_total     = snap_ff.errors;
      rsp_bus.last_interval_ms = snap_ff.recent;
      rsp_bus.max_interval_ms  = snap_ff.largest;
      rsp_bus.gaps_low         = snap_ff.gap_low;
      rsp_bus.gaps_mid         = snap_ff.gap_mid;
      rsp_bus.gaps_high        = snap_ff.gap_high;
      rsp_bus.recent_gap_ms    = snap_ff.gap_ms;
      rsp_bus.last_gap_packet  = snap_ff.gap_packet;
      rsp_bus.rate_average     = snap_ff.average;
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int OPW = pas_pkg::OP_WIDTH;
   localparam int BCW = pas_pkg::BYTE_COUNT_WIDTH;
   localparam int TW  = pas_pkg::TIME_WIDTH;
   localparam int CTW = pas_pkg::COUNTER_WIDTH;
   localparam int BSW = pas_pkg::BYTE_SUM_WIDTH;
   localparam int IW  = pas_pkg::INTERVAL_WIDTH;
   localparam int RW  = pas_pkg::RATE_WIDTH;
   localparam int CIW = pas_pkg::CSR_INDEX_WIDTH;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 50;
   localparam int MAX_REPORTS = 10;
   // Index 3 addresses no register, so a write there must be dropped.
   localparam logic [CIW-1:0] CSR_NO_REGISTER = 2'd3;

   typedef struct {
      logic [CTW-1:0] packets;
      logic [BSW-1:0] bytes;
      logic [CTW-1:0] timeouts;
      logic [CTW-1:0] errors;
      logic [IW-1:0]  last_interval;
      logic [IW-1:0]  max_interval;
      logic [CTW-1:0] gaps [3];
      logic [IW-1:0]  gap_size;
      logic [CTW-1:0] gap_packet;
      logic [RW-1:0]  rate;
   } stats_snapshot_type;

   logic clock;
   logic reset;

   pas_req_if req_bus ();
   pas_rsp_if rsp_bus ();
   pas_csr_if csr_bus ();

   packet_arrival_statistics dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Mirror of the block's thresholds and statistics.
   logic [IW-1:0]  gap_threshold [3];
   logic [TW-1:0]  last_arrival_us;
   logic           have_packet;
   logic [CTW-1:0] packet_count;
   logic [BSW-1:0] byte_sum;
   logic [CTW-1:0] timeout_count;
   logic [CTW-1:0] error_count;
   logic [IW-1:0]  interval_ms;
   logic [IW-1:0]  interval_max_ms;
   logic [CTW-1:0] gap_count [3];
   logic [IW-1:0]  gap_size_ms;
   logic [CTW-1:0] gap_packet_number;
   logic [RW-1:0]  rate_avg;

   stats_snapshot_type expected_snapshots [$];

   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count;
   int mismatch_count;
   int snapshots_checked;
   int packets_sent;
   int timeouts_sent;
   int errors_sent;
   int clears_sent;
   int register_writes;
   logic [TW-1:0] stream_time_us;

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [CTW-1:0] saturating_increment(logic [CTW-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   function automatic void clear_statistics();
      last_arrival_us = '0;
      have_packet = 1'b0;
      packet_count = '0;
      byte_sum = '0;
      timeout_count = '0;
      error_count = '0;
      interval_ms = '0;
      interval_max_ms = '0;
      for (int i = 0; i < 3; i++) gap_count[i] = '0;
      gap_size_ms = '0;
      gap_packet_number = '0;
      rate_avg = '0;
   endfunction

   // Applies one event to the mirrored statistics and returns the snapshot.
   function automatic stats_snapshot_type update_statistics(logic [OPW-1:0] op,
                                                            logic [BCW-1:0] bytes,
                                                            logic [TW-1:0] now_us);
      stats_snapshot_type snap;
      logic [BCW-1:0] length;
      logic [BSW:0]   sum;
      logic [TW-1:0]  dt;
      logic [IW-1:0]  ms;
      logic [63:0]    inst;
      logic [63:0]    acc;
      case (op)
         pas_pkg::OP_PACKET: begin
            // Zero-length packets leave every statistic alone.
            if (bytes != '0) begin
               length = (bytes > BCW'(pas_pkg::MAX_PACKET_BYTES))
                        ? BCW'(pas_pkg::MAX_PACKET_BYTES) : bytes;
               packet_count = saturating_increment(packet_count);
               sum = {1'b0, byte_sum} + (BSW+1)'(length);
               byte_sum = sum[BSW] ? '1 : sum[BSW-1:0];
               if (have_packet) begin
                  dt = now_us - last_arrival_us;
                  ms = IW'(dt / TW'(pas_pkg::US_PER_MS));
                  // The moving average skips a zero interarrival.
                  if (dt != '0) begin
                     inst = (64'(pas_pkg::US_PER_SECOND) << pas_pkg::RATE_FRACTION_BITS)
                            / {32'd0, dt};
                     if (inst > 64'({RW{1'b1}})) inst = 64'({RW{1'b1}});
                     if (rate_avg == '0) begin
                        rate_avg = inst[RW-1:0];
                     end else begin
                        acc = (64'(pas_pkg::ALPHA_Q16) * inst
                               + 64'((1 << pas_pkg::ALPHA_BITS) - pas_pkg::ALPHA_Q16)
                                 * 64'(rate_avg))
                              >> pas_pkg::ALPHA_BITS;
                        if (acc > 64'({RW{1'b1}})) acc = 64'({RW{1'b1}});
                        rate_avg = acc[RW-1:0];
                     end
                  end
                  interval_ms = ms;
                  if (ms > interval_max_ms) interval_max_ms = ms;
                  if (ms >= gap_threshold[pas_pkg::CSR_GAP_LOW]) begin
                     gap_count[0] = saturating_increment(gap_count[0]);
                     gap_size_ms = ms;
                     gap_packet_number = packet_count;
                  end
                  if (ms >= gap_threshold[pas_pkg::CSR_GAP_MID])
                     gap_count[1] = saturating_increment(gap_count[1]);
                  if (ms >= gap_threshold[pas_pkg::CSR_GAP_HIGH])
                     gap_count[2] = saturating_increment(gap_count[2]);
               end
               last_arrival_us = now_us;
               have_packet = 1'b1;
            end
         end
         pas_pkg::OP_TIMEOUT: timeout_count = saturating_increment(timeout_count);
         pas_pkg::OP_ERROR:   error_count = saturating_increment(error_count);
         default:             clear_statistics();
      endcase
      snap.packets = packet_count;
      snap.bytes = byte_sum;
      snap.timeouts = timeout_count;
      snap.errors = error_count;
      snap.last_interval = interval_ms;
      snap.max_interval = interval_max_ms;
      for (int i = 0; i < 3; i++) snap.gaps[i] = gap_count[i];
      snap.gap_size = gap_size_ms;
      snap.gap_packet = gap_packet_number;
      snap.rate = rate_avg;
      return snap;
   endfunction

   function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h",
                     $realtime, label, want, got);
      end
   endfunction

   // Sends one event beat, with random idle cycles ahead of it, and records the
   // snapshot it must produce once the beat is taken.
   task automatic send_event(logic [OPW-1:0] op, logic [BCW-1:0] bytes,
                             logic [TW-1:0] now_us);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.operation = op;
      req_bus.byte_count = bytes;
      req_bus.arrival_time_us = now_us;
      do @(posedge clock); while (!req_bus.ready);
      expected_snapshots.push_back(update_statistics(op, bytes, now_us));
      case (op)
         pas_pkg::OP_PACKET:  packets_sent++;
         pas_pkg::OP_TIMEOUT: timeouts_sent++;
         pas_pkg::OP_ERROR:   errors_sent++;
         default:             clears_sent++;
      endcase
   endtask

   // Stops the event stream and waits until the block has nothing in flight.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CIW-1:0] index, logic [IW-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data = value;
      do @(posedge clock); while (!csr_bus.ready);
      if (index != CSR_NO_REGISTER) gap_threshold[index] = value;
      register_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Every event kind and the packet corner cases under the reset thresholds.
   task automatic test_directed_events();
      send_event(pas_pkg::OP_TIMEOUT, 13'h1FFF, 32'h0);
      send_event(pas_pkg::OP_ERROR, 13'h0, 32'hFFFF_FFFF);
      // A zero-length packet is dropped, even before the first packet.
      send_event(pas_pkg::OP_PACKET, 13'd0, 32'd100);
      // The first packet is counted and stores its time; it gives no interval yet.
      send_event(pas_pkg::OP_PACKET, 13'd1, 32'd0);
      // Same timestamp: zero interval, no rate update.
      send_event(pas_pkg::OP_PACKET, 13'd4096, 32'd0);
      // One microsecond later: fastest rate seeds the average; length is clipped.
      send_event(pas_pkg::OP_PACKET, 13'd4097, 32'd1);
      send_event(pas_pkg::OP_PACKET, 13'h1FFF, 32'd300_001);
      send_event(pas_pkg::OP_PACKET, 13'd100, 32'd800_000);
      send_event(pas_pkg::OP_PACKET, 13'd100, 32'd1_300_000);
      send_event(pas_pkg::OP_PACKET, 13'd100, 32'd2_300_000);
      // Timestamp wrap between two packets.
      send_event(pas_pkg::OP_PACKET, 13'd64, 32'hFFFF_FFF0);
      send_event(pas_pkg::OP_PACKET, 13'd64, 32'h0000_0010);
      send_event(pas_pkg::OP_PACKET, 13'd0, 32'd5);
      send_event(pas_pkg::OP_CLEAR, 13'd0, 32'd0);
      // After a clear the next packet is a first packet again.
      send_event(pas_pkg::OP_PACKET, 13'd1500, 32'hFFFF_FFFF);
      // Largest possible interval: rate rounds to zero, so no seed yet.
      send_event(pas_pkg::OP_PACKET, 13'd1500, 32'hFFFF_FFFE);
      send_event(pas_pkg::OP_PACKET, 13'd1500, 32'hFFFF_FFFE + 32'd999);
      send_event(pas_pkg::OP_TIMEOUT, 13'd0, 32'd0);
      send_event(pas_pkg::OP_ERROR, 13'h1FFF, 32'h0);
      send_event(pas_pkg::OP_CLEAR, 13'h1FFF, 32'hFFFF_FFFF);
   endtask

   // Thresholds at zero and at or above the largest interval, plus a write to no register.
   task automatic test_threshold_extremes();
      wait_idle();
      write_register(pas_pkg::CSR_GAP_LOW, '0);
      write_register(pas_pkg::CSR_GAP_MID, '0);
      write_register(pas_pkg::CSR_GAP_HIGH, '0);
      send_event(pas_pkg::OP_PACKET, 13'd200, 32'h8000_0000);
      send_event(pas_pkg::OP_PACKET, 13'd200, 32'h8000_01F4);
      wait_idle();
      write_register(CSR_NO_REGISTER, '1);
      write_register(pas_pkg::CSR_GAP_LOW, '1);
      write_register(pas_pkg::CSR_GAP_MID, IW'(4294967));
      write_register(pas_pkg::CSR_GAP_HIGH, IW'(4294967));
      send_event(pas_pkg::OP_PACKET, 13'd200, 32'h8000_01F3);
      wait_idle();
   endtask

   // Mostly packets with interarrival times spread over every threshold,
   // mixed with timeouts, errors, odd lengths and the occasional clear.
   task automatic test_random_stream(int items, int send_pct, int recv_pct,
                                     logic [IW-1:0] low,
                                     logic [IW-1:0] mid,
                                     logic [IW-1:0] high);
      int pick;
      int k;
      logic [TW-1:0] dt;
      logic [BCW-1:0] bytes;
      wait_idle();
      write_register(pas_pkg::CSR_GAP_HIGH, high);
      write_register(pas_pkg::CSR_GAP_LOW, low);
      write_register(CSR_NO_REGISTER, IW'($urandom));
      write_register(pas_pkg::CSR_GAP_MID, mid);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         if (pick < 84) begin
            pick = $urandom_range(99);
            if (pick < 28) dt = $urandom_range(999);
            else if (pick < 52) dt = $urandom_range(2_000_000, 1000);
            else if (pick < 78) begin
               k = $urandom_range(2);
               dt = TW'(gap_threshold[k]) * TW'(pas_pkg::US_PER_MS)
                    + $urandom_range(1999) - 32'd1000;
            end
            else if (pick < 87) dt = $urandom_range(20_000_000);
            else if (pick < 94) dt = $urandom;
            else dt = '0;
            stream_time_us = stream_time_us + dt;
            pick = $urandom_range(99);
            if (pick < 90) bytes = BCW'($urandom_range(pas_pkg::MAX_PACKET_BYTES, 1));
            else if (pick < 94) bytes = '0;
            else bytes = BCW'($urandom_range((1 << BCW) - 1, pas_pkg::MAX_PACKET_BYTES + 1));
            send_event(pas_pkg::OP_PACKET, bytes, stream_time_us);
         end
         else if (pick < 91) send_event(pas_pkg::OP_TIMEOUT, BCW'($urandom), $urandom);
         else if (pick < 99) send_event(pas_pkg::OP_ERROR, BCW'($urandom), $urandom);
         else send_event(pas_pkg::OP_CLEAR, BCW'($urandom), $urandom);
      end
   endtask

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Snapshot checker.
   always @(posedge clock) begin
      stats_snapshot_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_snapshots.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0t] snapshot beat with no event waiting for it", $realtime);
         end else begin
            want = expected_snapshots.pop_front();
            check_field("packet_tally", 64'(want.packets), 64'(rsp_bus.packet_tally));
            check_field("byte_tally", 64'(want.bytes), 64'(rsp_bus.byte_tally));
            check_field("timeouts_total", 64'(want.timeouts), 64'(rsp_bus.timeouts_total));
            check_field("errors_total", 64'(want.errors), 64'(rsp_bus.errors_total));
            check_field("last_interval_ms", 64'(want.last_interval),
                        64'(rsp_bus.last_interval_ms));
            check_field("max_interval_ms", 64'(want.max_interval),
                        64'(rsp_bus.max_interval_ms));
            check_field("gaps_low", 64'(want.gaps[0]), 64'(rsp_bus.gaps_low));
            check_field("gaps_mid", 64'(want.gaps[1]), 64'(rsp_bus.gaps_mid));
            check_field("gaps_high", 64'(want.gaps[2]), 64'(rsp_bus.gaps_high));
            check_field("recent_gap_ms", 64'(want.gap_size), 64'(rsp_bus.recent_gap_ms));
            check_field("last_gap_packet", 64'(want.gap_packet),
                        64'(rsp_bus.last_gap_packet));
            check_field("rate_average", 64'(want.rate), 64'(rsp_bus.rate_average));
            snapshots_checked++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] run did not complete in %0d cycles", $realtime, CYCLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [IW-1:0] low;
      logic [IW-1:0] mid;
      logic [IW-1:0] high;
      cycle_count = 0;
      mismatch_count = 0;
      snapshots_checked = 0;
      packets_sent = 0;
      timeouts_sent = 0;
      errors_sent = 0;
      clears_sent = 0;
      register_writes = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stream_time_us = $urandom;
      gap_threshold[pas_pkg::CSR_GAP_LOW] = pas_pkg::GAP_LOW_RESET;
      gap_threshold[pas_pkg::CSR_GAP_MID] = pas_pkg::GAP_MID_RESET;
      gap_threshold[pas_pkg::CSR_GAP_HIGH] = pas_pkg::GAP_HIGH_RESET;
      clear_statistics();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = pas_pkg::OP_PACKET;
      req_bus.byte_count = '0;
      req_bus.arrival_time_us = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = pas_pkg::CSR_GAP_LOW;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_events();
      test_threshold_extremes();

      // Thresholds in order and near their usual range.
      low = IW'($urandom_range(800));
      mid = low + IW'($urandom_range(800));
      high = mid + IW'($urandom_range(1500));
      test_random_stream(642, 34, 80, low, mid, high);

      // Thresholds anywhere, either small or over the full register width.
      low = ($urandom_range(1) != 0) ? IW'($urandom) : IW'($urandom_range(3000));
      mid = ($urandom_range(1) != 0) ? IW'($urandom) : IW'($urandom_range(3000));
      high = ($urandom_range(1) != 0) ? IW'($urandom) : IW'($urandom_range(3000));
      test_random_stream(642, 80, 34, low, mid, high);

      test_random_stream(642, 0, 0, pas_pkg::GAP_LOW_RESET, pas_pkg::GAP_MID_RESET,
                         pas_pkg::GAP_HIGH_RESET);

      wait_idle();
      $display("Checked %0d snapshots: %0d packets, %0d timeouts, %0d errors, %0d clears.",
               snapshots_checked, packets_sent, timeouts_sent, errors_sent, clears_sent);
      $display("%0d threshold writes; %0d field mismatches found.",
               register_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
sv/pas_pkg.sv
sv/pas_channels.sv
sv/pas_divider.sv
sv/packet_arrival_statistics.sv
bench/tb_top.sv
